// ===== design/saq_pkg.sv =====
// shared types and constants for the substring anagram query block
// no dependencies; imported by every module of the block but saq_ram
`timescale 1ns / 1ps
`default_nettype none

package saq_pkg;

    localparam int unsigned MAX_LEN_DEF  = 1024;
    localparam int unsigned ALPHABET_DEF = 26;

    // input field widths, fixed by the stream format
    localparam int unsigned CMD_W  = 2;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned IDX_W  = 11;

    // s_tdata layout, lowest bit first
    localparam int unsigned CHAR_LSB = 0;
    localparam int unsigned S1_LSB   = CHAR_LSB + CHAR_W;
    localparam int unsigned E1_LSB   = S1_LSB + IDX_W;
    localparam int unsigned S2_LSB   = E1_LSB + IDX_W;
    localparam int unsigned E2_LSB   = S2_LSB + IDX_W;
    localparam int unsigned IN_BITS  = E2_LSB + IDX_W;
    localparam int unsigned IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int unsigned OUT_DATA_W = 8;

    localparam int unsigned CHAR_LOW  = 'h61;
    localparam int unsigned CHAR_HIGH = 'h7a;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_QUERY  = 2'd0,
        STAT_STORED = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_RANGE  = 2'd3
    } status_t;

    // which table row a query read fetches
    typedef enum logic [1:0] {
        ROW_END1 = 2'd0,
        ROW_PRE1 = 2'd1,
        ROW_END2 = 2'd2,
        ROW_PRE2 = 2'd3
    } row_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_APP_RD,
        S_APP_WR,
        S_Q_RD0,
        S_Q_RD1,
        S_Q_RD2,
        S_Q_RD3,
        S_Q_LAST,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic     in_load;
        logic     clear_len;
        logic     rd_en;
        logic     rd_app;
        row_sel_t rd_sel;
        logic     app_write;
        logic     acc_clr;
        logic     acc_en;
        logic     out_load;
        status_t  out_status;
    } ctl_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             range_bad;
        logic             out_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/substring_anagram_query.sv =====
// Substring anagram query block, top level.
// Input stream (s_*): one transaction per command. s_tuser carries the command:
// append a character, query two 1-based inclusive ranges, or clear the string.
// Appends build a prefix table of per-letter counts, one row per character;
// a query compares the letter counts of its two ranges from four table rows.
// Output stream (m_*): one transaction per append, query or clear, carrying
// is_anagram and a status (query done, stored/cleared, table full, bad index).
// Unused command codes are taken and give no result.
// One command is worked on at a time, and a new one is not accepted until the
// last has loaded its result: a query reads its four rows one after another
// through the single read port of the row-wide table memory, an append reads
// the last row and writes the row after it.
// The result sits in an output register; the next command is accepted while
// it waits, and only the following result waits for the receiver to take it.
// Reset empties the string and drops a pending result; row zero of the table
// reads as zero without being written, so no clearing pass is needed.
// depends on saq_pkg, saq_controller, saq_datapath, saq_ram
`timescale 1ns / 1ps
`default_nettype none

module substring_anagram_query #(
    parameter int unsigned MAX_LEN  = saq_pkg::MAX_LEN_DEF,
    parameter int unsigned ALPHABET = saq_pkg::ALPHABET_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // char_byte, first_start, first_end, second_start, second_end
    input  wire logic [saq_pkg::IN_DATA_W-1:0]  s_tdata,
    // cmd
    input  wire logic [saq_pkg::CMD_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // is_anagram, status
    output logic      [saq_pkg::OUT_DATA_W-1:0] m_tdata
);
    import saq_pkg::*;

    ctl_cmd_t ctl;
    dp_stat_t stat;

    saq_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    saq_datapath #(
        .MAX_LEN  (MAX_LEN),
        .ALPHABET (ALPHABET)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .ctl      (ctl),
        .stat     (stat),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

    // one command at a time: an accepted transaction closes the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a command is in progress");

    // a result is never loaded over one the receiver has not taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_load |-> !(m_tvalid && !m_tready))
        else $error("result register overwritten");

    // the table is written only by an append with room left
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.app_write |-> (stat.cmd == CMD_APPEND) && !stat.full)
        else $error("table write outside an append");

endmodule

`default_nettype wire

// ===== design/saq_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module saq_ram #(
    parameter int unsigned DATA_W = 8,
    parameter int unsigned DEPTH  = 2,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/saq_datapath.sv =====
// datapath: input capture, loaded length, prefix table, per-letter difference
// accumulators and result register; depends on saq_pkg and saq_ram
`timescale 1ns / 1ps
`default_nettype none

module saq_datapath #(
    parameter int unsigned MAX_LEN  = saq_pkg::MAX_LEN_DEF,
    parameter int unsigned ALPHABET = saq_pkg::ALPHABET_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [saq_pkg::IN_DATA_W-1:0]     s_tdata,
    input  wire logic [saq_pkg::CMD_W-1:0]         s_tuser,
    input  wire saq_pkg::ctl_cmd_t                 ctl,
    output saq_pkg::dp_stat_t                      stat,
    input  wire logic                              m_tready,
    output logic                                   m_tvalid,
    output logic      [saq_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import saq_pkg::*;

    localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);
    localparam int unsigned CNT_W = LEN_W;
    localparam int unsigned CMP_W = (LEN_W > IDX_W) ? LEN_W : IDX_W;
    localparam int unsigned ROW_W = ALPHABET * CNT_W;
    localparam int unsigned ACC_W = CNT_W + 2;

    logic [CMD_W-1:0]  cmd_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [IDX_W-1:0]  s1_reg, e1_reg, s2_reg, e2_reg;
    logic [LEN_W-1:0]  len_reg, len_next;

    logic [CMP_W-1:0] s1x, e1x, s2x, e2x, lenx, s1m, s2m, rd_row;
    logic             range1_ok, range2_ok;

    logic [LEN_W-1:0] rd_addr, wr_addr;
    logic [ROW_W-1:0] rd_data, wr_data;
    logic             rd_zero_reg;
    logic             acc_neg_reg;

    logic signed [ACC_W-1:0] acc_reg  [ALPHABET];
    logic signed [ACC_W-1:0] acc_next [ALPHABET];
    logic [ALPHABET-1:0]     lane_nz;
    logic [ALPHABET-1:0]     hit;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    // input capture
    always_ff @(posedge aclk) begin
        if (ctl.in_load) begin
            cmd_reg  <= s_tuser;
            char_reg <= s_tdata[CHAR_LSB +: CHAR_W];
            s1_reg   <= s_tdata[S1_LSB +: IDX_W];
            e1_reg   <= s_tdata[E1_LSB +: IDX_W];
            s2_reg   <= s_tdata[S2_LSB +: IDX_W];
            e2_reg   <= s_tdata[E2_LSB +: IDX_W];
        end
    end

    always_comb begin
        len_next = len_reg;
        if (ctl.clear_len) begin
            len_next = '0;
        end else if (ctl.app_write) begin
            len_next = len_reg + LEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else begin
            len_reg <= len_next;
        end
    end

    assign s1x  = CMP_W'(s1_reg);
    assign e1x  = CMP_W'(e1_reg);
    assign s2x  = CMP_W'(s2_reg);
    assign e2x  = CMP_W'(e2_reg);
    assign lenx = CMP_W'(len_reg);
    assign s1m  = s1x - CMP_W'(1);
    assign s2m  = s2x - CMP_W'(1);

    assign range1_ok = (s1x != '0) && (s1x <= lenx) && (e1x <= lenx);
    assign range2_ok = (s2x != '0) && (s2x <= lenx) && (e2x <= lenx);

    assign stat.cmd       = cmd_reg;
    assign stat.full      = (lenx == CMP_W'(MAX_LEN));
    assign stat.range_bad = !(range1_ok && range2_ok);
    assign stat.out_busy  = m_tvalid_reg && !m_tready;

    always_comb begin
        unique case (ctl.rd_sel)
            ROW_END1: rd_row = e1x;
            ROW_PRE1: rd_row = s1m;
            ROW_END2: rd_row = e2x;
            ROW_PRE2: rd_row = s2m;
            default:  rd_row = e1x;
        endcase
    end

    assign rd_addr = ctl.rd_app ? len_reg : rd_row[LEN_W-1:0];
    assign wr_addr = len_reg + LEN_W'(1);

    // row zero is never written: its reads are forced to zero
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_zero_reg <= (rd_addr == '0);
            acc_neg_reg <= (ctl.rd_sel == ROW_PRE1) || (ctl.rd_sel == ROW_END2);
        end
    end

    saq_ram #(
        .DATA_W (ROW_W),
        .DEPTH  (MAX_LEN + 1),
        .ADDR_W (LEN_W)
    ) u_table (
        .clk   (aclk),
        .we    (ctl.app_write),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (ctl.rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // one lane per letter: append increment and signed difference accumulate
    for (genvar k = 0; k < ALPHABET; k++) begin : g_lane
        localparam int unsigned LCODE = CHAR_LOW + k;
        logic [CNT_W-1:0] row_cnt;

        if (LCODE <= CHAR_HIGH) begin : g_letter
            assign hit[k] = (char_reg == CHAR_W'(LCODE));
        end else begin : g_none
            assign hit[k] = 1'b0;
        end

        assign row_cnt = rd_zero_reg ? '0 : rd_data[k*CNT_W +: CNT_W];
        assign wr_data[k*CNT_W +: CNT_W] = row_cnt + CNT_W'(hit[k]);

        always_comb begin
            acc_next[k] = acc_reg[k];
            if (ctl.acc_clr) begin
                acc_next[k] = '0;
            end else if (ctl.acc_en) begin
                if (acc_neg_reg) begin
                    acc_next[k] = acc_reg[k] - $signed(ACC_W'(row_cnt));
                end else begin
                    acc_next[k] = acc_reg[k] + $signed(ACC_W'(row_cnt));
                end
            end
        end

        always_ff @(posedge aclk) begin
            acc_reg[k] <= acc_next[k];
        end

        assign lane_nz[k] = (acc_reg[k] != '0);
    end

    // result register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (ctl.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            m_tdata_reg <= OUT_DATA_W'({ctl.out_status,
                ((ctl.out_status == STAT_QUERY) && !(|lane_nz))});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ===== design/saq_controller.sv =====
// controller state machine: sequences appends, queries and clears
// depends on saq_pkg; drives the datapath through ctl_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module saq_controller (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire saq_pkg::dp_stat_t stat,
    output saq_pkg::ctl_cmd_t      ctl
);
    import saq_pkg::*;

    state_t  state_reg, state_next;
    status_t status_reg, status_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= STAT_QUERY;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        status_next    = status_reg;
        ctl            = '0;
        ctl.rd_sel     = ROW_END1;
        ctl.out_status = status_reg;
        s_tready       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_tready    = 1'b1;
                ctl.in_load = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (stat.cmd)
                    CMD_APPEND: begin
                        if (stat.full) begin
                            status_next = STAT_FULL;
                            state_next  = S_FINISH;
                        end else begin
                            state_next = S_APP_RD;
                        end
                    end
                    CMD_QUERY: begin
                        if (stat.range_bad) begin
                            status_next = STAT_RANGE;
                            state_next  = S_FINISH;
                        end else begin
                            state_next = S_Q_RD0;
                        end
                    end
                    CMD_CLEAR: begin
                        ctl.clear_len = 1'b1;
                        status_next   = STAT_STORED;
                        state_next    = S_FINISH;
                    end
                    // unused command: no result
                    default: state_next = S_IDLE;
                endcase
            end
            S_APP_RD: begin
                ctl.rd_en  = 1'b1;
                ctl.rd_app = 1'b1;
                state_next = S_APP_WR;
            end
            S_APP_WR: begin
                ctl.app_write = 1'b1;
                status_next   = STAT_STORED;
                state_next    = S_FINISH;
            end
            S_Q_RD0: begin
                ctl.rd_en   = 1'b1;
                ctl.rd_sel  = ROW_END1;
                ctl.acc_clr = 1'b1;
                state_next  = S_Q_RD1;
            end
            S_Q_RD1: begin
                ctl.rd_en  = 1'b1;
                ctl.rd_sel = ROW_PRE1;
                ctl.acc_en = 1'b1;
                state_next = S_Q_RD2;
            end
            S_Q_RD2: begin
                ctl.rd_en  = 1'b1;
                ctl.rd_sel = ROW_END2;
                ctl.acc_en = 1'b1;
                state_next = S_Q_RD3;
            end
            S_Q_RD3: begin
                ctl.rd_en  = 1'b1;
                ctl.rd_sel = ROW_PRE2;
                ctl.acc_en = 1'b1;
                state_next = S_Q_LAST;
            end
            S_Q_LAST: begin
                ctl.acc_en  = 1'b1;
                status_next = STAT_QUERY;
                state_next  = S_FINISH;
            end
            S_FINISH: begin
                // wait for the result register to drain
                if (!stat.out_busy) begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== sim/saq_checker.sv =====
// checker for the substring anagram query block: watches both streams, keeps its own
// prefix letter table, predicts one answer per command but an unused one and compares in order
// depends on saq_pkg
`timescale 1ns / 1ps

module saq_checker #(
    parameter int unsigned MAX_LEN  = saq_pkg::MAX_LEN_DEF,
    parameter int unsigned ALPHABET = saq_pkg::ALPHABET_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [saq_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [saq_pkg::CMD_W-1:0]      s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [saq_pkg::OUT_DATA_W-1:0] m_tdata,
    output int                             mismatches,
    output int                             pending
);
    import saq_pkg::*;

    // m_tdata layout, lowest bit first: is_anagram, status
    localparam int unsigned ANS_BIT  = 0;
    localparam int unsigned STAT_LSB = 1;

    typedef struct packed {
        logic    is_anagram;
        status_t status;
    } answer_t;

    logic [IDX_W-1:0] prefix_tab [0:MAX_LEN][0:ALPHABET-1];
    int unsigned      loaded_len;
    answer_t          answer_q[$];
    int               err_cnt;

    function automatic bit range_ok(int unsigned start, int unsigned stop);
        return start >= 1 && start <= loaded_len && stop <= loaded_len;
    endfunction

    // exact signed count of one letter, zero or negative when start passes end
    function automatic int letters_in(int unsigned start, int unsigned stop, int unsigned k);
        return int'(prefix_tab[stop][k]) - int'(prefix_tab[start-1][k]);
    endfunction

    task automatic predict_answer(input logic [CMD_W-1:0] cmd,
                                  input logic [IN_DATA_W-1:0] d);
        logic [CHAR_W-1:0] ch;
        int unsigned       s1, e1, s2, e2, k;
        answer_t           ans;
        ch = d[CHAR_LSB +: CHAR_W];
        s1 = 32'(d[S1_LSB +: IDX_W]);
        e1 = 32'(d[E1_LSB +: IDX_W]);
        s2 = 32'(d[S2_LSB +: IDX_W]);
        e2 = 32'(d[E2_LSB +: IDX_W]);
        ans.is_anagram = 1'b0;
        ans.status     = STAT_STORED;
        case (cmd)
            CMD_APPEND: begin
                if (loaded_len >= MAX_LEN) begin
                    ans.status = STAT_FULL;
                end else begin
                    for (k = 0; k < ALPHABET; k++)
                        prefix_tab[loaded_len+1][k] = prefix_tab[loaded_len][k];
                    if (ch >= CHAR_LOW && ch <= CHAR_HIGH && ch - CHAR_LOW < ALPHABET)
                        prefix_tab[loaded_len+1][ch-CHAR_LOW] += 1'b1;
                    loaded_len++;
                end
            end
            CMD_QUERY: begin
                if (!range_ok(s1, e1) || !range_ok(s2, e2)) begin
                    ans.status = STAT_RANGE;
                end else begin
                    ans.status     = STAT_QUERY;
                    ans.is_anagram = 1'b1;
                    for (k = 0; k < ALPHABET; k++)
                        if (letters_in(s1, e1, k) != letters_in(s2, e2, k))
                            ans.is_anagram = 1'b0;
                end
            end
            CMD_CLEAR: begin
                loaded_len = 0;
            end
            default: begin
                // unused command: taken with no answer
                return;
            end
        endcase
        answer_q.push_back(ans);
    endtask

    always @(posedge aclk) begin : watch
        answer_t want;
        if (!aresetn) begin
            answer_q.delete();
            loaded_len = 0;
            err_cnt    = 0;
            for (int unsigned k = 0; k < ALPHABET; k++)
                prefix_tab[0][k] = '0;
        end else begin
            // compare before predicting so a new command never meets its own answer
            if (m_tvalid && m_tready) begin
                if (answer_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: result with nothing expected, is_anagram %0b status %0d",
                                 $realtime, m_tdata[ANS_BIT], m_tdata[STAT_LSB +: 2]);
                end else begin
                    want = answer_q.pop_front();
                    if (m_tdata[ANS_BIT] !== want.is_anagram
                            || m_tdata[STAT_LSB +: 2] !== want.status) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display({"%0t: mismatch, expected is_anagram %0b status %0d,",
                                      " got is_anagram %0b status %0d"},
                                     $realtime, want.is_anagram, want.status,
                                     m_tdata[ANS_BIT], m_tdata[STAT_LSB +: 2]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_answer(s_tuser, s_tdata);
        end
        mismatches <= err_cnt;
        pending    <= answer_q.size();
    end

endmodule

// ===== sim/tb_substring_anagram_query.sv =====
// testbench top for the substring anagram query block: clock, reset, directed and
// random command streams, receiver back-pressure and the final verdict
// depends on saq_pkg, saq_checker and the block's rtl
`timescale 1ns / 1ps

module tb_substring_anagram_query;
    import saq_pkg::*;

    localparam int unsigned MAX_LEN     = MAX_LEN_DEF;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned LONG_LEN    = 200;
    localparam int          RAND_ITEMS  = 290;
    localparam int          CALM_ITEMS  = 60;
    localparam int          HOLD_AT     = 40;
    localparam int          HOLD_CYCLES = 200;
    localparam int unsigned IDX_MAX     = (1 << IDX_W) - 1;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [CMD_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    int                    mismatches;
    int                    pending;

    bit                    calm = 1'b0;
    int                    sent_cnt = 0;
    int unsigned           str_len = 0;

    always #5 aclk = ~aclk;

    substring_anagram_query dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    saq_checker #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET_DEF)) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // one transaction on the input stream, at times with a random gap ahead of it
    task automatic send_item(input logic [CMD_W-1:0] cmd, input int unsigned ch,
                             input int unsigned s1, input int unsigned e1,
                             input int unsigned s2, input int unsigned e2);
        logic [IN_DATA_W-1:0] pkt;
        pkt = '0;
        pkt[CHAR_LSB +: CHAR_W] = CHAR_W'(ch);
        pkt[S1_LSB +: IDX_W]    = IDX_W'(s1);
        pkt[E1_LSB +: IDX_W]    = IDX_W'(e1);
        pkt[S2_LSB +: IDX_W]    = IDX_W'(s2);
        pkt[E2_LSB +: IDX_W]    = IDX_W'(e2);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= pkt;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_cnt++;
        if (cmd == CMD_APPEND && str_len < MAX_LEN)
            str_len++;
        else if (cmd == CMD_CLEAR)
            str_len = 0;
    endtask

    // stop offering and wait for every outstanding answer
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin : receiver
        bit held;
        held = 1'b0;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && sent_cnt >= HOLD_AT) begin
                // long hold so the block backs up into its input
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    initial begin : watchdog
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        int          rand_items, sel, r;
        int unsigned w, g, s1, e1, s2, e2;
        int unsigned ch;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_APPEND;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty string, odd bytes, empty and negative ranges, bad indexes
        send_item(CMD_QUERY, 0, 1, 1, 1, 1);
        send_item(CMD_CLEAR, 'hff, 0, 0, 0, 0);
        send_item(CMD_APPEND, CHAR_LOW, 0, 0, 0, 0);
        send_item(CMD_APPEND, CHAR_HIGH, IDX_MAX, IDX_MAX, IDX_MAX, IDX_MAX);
        send_item(CMD_APPEND, 0, 0, 0, 0, 0);
        send_item(CMD_APPEND, 'hff, 0, 0, 0, 0);
        send_item(CMD_APPEND, CHAR_LOW - 1, 0, 0, 0, 0);
        send_item(CMD_APPEND, CHAR_HIGH + 1, 0, 0, 0, 0);
        send_item(CMD_APPEND, CHAR_HIGH, 0, 0, 0, 0);
        send_item(CMD_APPEND, CHAR_LOW, 0, 0, 0, 0);
        send_item(CMD_QUERY, 0, 1, 2, 7, 8);
        send_item(CMD_QUERY, 0, 1, 1, 2, 2);
        send_item(CMD_QUERY, 'hff, 3, 4, 5, 6);
        send_item(CMD_QUERY, 0, 2, 1, 5, 4);
        send_item(CMD_QUERY, 0, 3, 1, 8, 6);
        send_item(CMD_QUERY, 0, 1, 0, 5, 4);
        send_item(CMD_QUERY, 0, 0, 2, 1, 2);
        send_item(CMD_QUERY, 0, 1, 9, 1, 8);
        send_item(CMD_QUERY, 0, 9, 8, 1, 1);
        send_item(CMD_QUERY, 'hff, IDX_MAX, IDX_MAX, IDX_MAX, IDX_MAX);
        send_item(CMD_UNUSED, 'hff, IDX_MAX, IDX_MAX, IDX_MAX, IDX_MAX);
        send_item(CMD_QUERY, 0, 1, 8, 1, 8);
        send_item(CMD_CLEAR, 0, 0, 0, 0, 0);
        send_item(CMD_QUERY, 0, 1, 1, 1, 1);
        send_item(CMD_APPEND, CHAR_LOW + 12, 0, 0, 0, 0);
        send_item(CMD_QUERY, 0, 1, 1, 1, 1);
        wait_drained();

        // build a long string, then query across it and just past its end
        repeat (LONG_LEN)
            send_item(CMD_APPEND, CHAR_LOW + $urandom_range(0, 3), $urandom_range(0, IDX_MAX),
                      $urandom_range(0, IDX_MAX), $urandom_range(0, IDX_MAX),
                      $urandom_range(0, IDX_MAX));
        send_item(CMD_QUERY, 0, 1, LONG_LEN, 1, LONG_LEN);
        send_item(CMD_QUERY, 0, 1, LONG_LEN / 2, LONG_LEN / 2 + 1, LONG_LEN);
        send_item(CMD_QUERY, 0, LONG_LEN, LONG_LEN, 1, 1);
        send_item(CMD_QUERY, 0, LONG_LEN + 1, LONG_LEN + 1, 1, 1);
        send_item(CMD_QUERY, 0, 1, 1, 1, LONG_LEN + 1);
        repeat (12) begin
            s1 = $urandom_range(1, LONG_LEN);
            e1 = $urandom_range(s1, LONG_LEN);
            s2 = $urandom_range(1, LONG_LEN - (e1 - s1));
            send_item(CMD_QUERY, 0, s1, e1, s2, s2 + e1 - s1);
        end
        wait_drained();
        send_item(CMD_CLEAR, 0, 0, 0, 0, 0);

        // random: short strings over few letters, mostly well-formed queries
        rand_items = 0;
        while (rand_items < RAND_ITEMS) begin
            if (rand_items >= RAND_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            sel = $urandom_range(0, 99);
            if (str_len > 900 || sel < 4) begin
                send_item(CMD_CLEAR, $urandom_range(0, 255), $urandom_range(0, IDX_MAX),
                          $urandom_range(0, IDX_MAX), $urandom_range(0, IDX_MAX),
                          $urandom_range(0, IDX_MAX));
                rand_items++;
            end else if (sel < 40 || str_len == 0) begin
                r = $urandom_range(0, 9);
                if (r < 7)
                    ch = CHAR_LOW + $urandom_range(0, 2);
                else if (r < 9)
                    ch = CHAR_LOW + $urandom_range(0, 25);
                else
                    ch = $urandom_range(0, 255);
                send_item(CMD_APPEND, ch, $urandom_range(0, IDX_MAX),
                          $urandom_range(0, IDX_MAX), $urandom_range(0, IDX_MAX),
                          $urandom_range(0, IDX_MAX));
                rand_items++;
            end else if (sel < 96) begin
                r = $urandom_range(0, 19);
                if (r < 12) begin
                    // equal widths give frequent anagrams
                    w  = $urandom_range(1, (str_len < 6) ? str_len : 6);
                    s1 = $urandom_range(1, str_len - w + 1);
                    s2 = $urandom_range(1, str_len - w + 1);
                    e1 = s1 + w - 1;
                    e2 = s2 + w - 1;
                end else if (r < 14) begin
                    // start past end, same gap on both sides
                    s1 = $urandom_range(1, str_len);
                    e1 = s1 - 1 - ((r == 13) ? $urandom_range(0, s1 - 1) : 0);
                    g  = s1 - e1;
                    s2 = $urandom_range(g, str_len);
                    e2 = s2 - g;
                end else if (r < 17) begin
                    s1 = $urandom_range(1, str_len);
                    e1 = $urandom_range(s1, str_len);
                    s2 = $urandom_range(1, str_len);
                    e2 = $urandom_range(s2, str_len);
                end else begin
                    s1 = $urandom_range(0, IDX_MAX);
                    e1 = $urandom_range(0, IDX_MAX);
                    s2 = $urandom_range(0, IDX_MAX);
                    e2 = $urandom_range(0, IDX_MAX);
                end
                send_item(CMD_QUERY, $urandom_range(0, 255), s1, e1, s2, e2);
                rand_items++;
            end else begin
                send_item(CMD_UNUSED, $urandom_range(0, 255), $urandom_range(0, IDX_MAX),
                          $urandom_range(0, IDX_MAX), $urandom_range(0, IDX_MAX),
                          $urandom_range(0, IDX_MAX));
            end
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
